FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/hdlcfr_pkg.sv
// Types and constants of the HDLC-style frame receiver.
`default_nettype none
package hdlcfr_pkg;
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam logic [7:0] RESET_ADDRESS = 8'h03;
	localparam logic [7:0] RESET_CONTROL = 8'h03;

	typedef enum logic {
		REG_ADDRESS = 1'b0,
		REG_CONTROL = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_GOT_FLAG  = 3'd1,
		PH_GOT_ADDR  = 3'd2,
		PH_GOT_CTRL  = 3'd3,
		PH_HEADER_OK = 3'd4,
		PH_SWALLOW   = 3'd5,
		PH_PAYLOAD   = 3'd6,
		PH_ESCAPED   = 3'd7
	} phase_t;
endpackage
`default_nettype wire

FILE: sv/hdlc_style_frame_receiver_top.sv
// HDLC-style frame receiver: checks the frame header, destuffs the payload, marks its end.
//
// One received byte enters per cycle while in_stall is low. A byte goes into an input
// register, from which the receiver state machine consumes it and may load one destuffed
// payload byte into the result register. Payload bytes leave one byte late: the closing
// flag releases the final byte with frame_last set. A stall on the output holds the state
// machine; the input register then fills and in_stall rises. Frames have no length limit.
`default_nettype none
`include "assert_macros.svh"
module hdlc_style_frame_receiver_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [7:0]                 cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      payload_byte,
	output logic                            frame_last
);
	import hdlcfr_pkg::*;

	logic [7:0] exp_addr_q;
	logic [7:0] exp_ctrl_q;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] held_byte_q;
	logic [7:0] held_byte_d;
	logic       held_valid_q;
	logic       held_valid_d;
	logic       out_valid_q;
	logic [7:0] payload_q;
	logic       last_q;
	logic       emit;
	logic       emit_last;
	logic       out_ready;
	logic       advance;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= RESET_ADDRESS;
			exp_ctrl_q <= RESET_CONTROL;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ADDRESS: exp_addr_q <= cfg_data;
				REG_CONTROL: exp_ctrl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Receiver state machine, next state and result.
	always_comb begin
		phase_d      = phase_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		emit         = 1'b0;
		emit_last    = 1'b0;
		unique case (phase_q) inside
			PH_IDLE: begin
				if (rx_byte_s1 == FLAG_BYTE) phase_d = PH_GOT_FLAG;
			end
			PH_GOT_FLAG: begin
				if (rx_byte_s1 == exp_addr_q) phase_d = PH_GOT_ADDR;
				else if (rx_byte_s1 != FLAG_BYTE) phase_d = PH_IDLE;
			end
			PH_GOT_ADDR: begin
				phase_d = (rx_byte_s1 == exp_ctrl_q) ? PH_GOT_CTRL : PH_IDLE;
			end
			PH_GOT_CTRL: begin
				phase_d = (rx_byte_s1 == (exp_addr_q ^ exp_ctrl_q)) ? PH_HEADER_OK : PH_IDLE;
			end
			PH_SWALLOW: begin
				phase_d = PH_IDLE;
			end
			PH_HEADER_OK, PH_PAYLOAD: begin
				if (rx_byte_s1 == FLAG_BYTE) begin
					if (phase_q == PH_PAYLOAD) begin
						emit         = held_valid_q;
						emit_last    = 1'b1;
						held_valid_d = 1'b0;
						phase_d      = PH_IDLE;
					end else begin
						phase_d = PH_SWALLOW;
					end
				end else if (rx_byte_s1 == ESC_BYTE) begin
					phase_d = PH_ESCAPED;
				end else begin
					emit         = held_valid_q;
					held_byte_d  = rx_byte_s1;
					held_valid_d = 1'b1;
					phase_d      = PH_PAYLOAD;
				end
			end
			PH_ESCAPED: begin
				emit         = held_valid_q;
				held_byte_d  = rx_byte_s1 ^ ESC_XOR;
				held_valid_d = 1'b1;
				phase_d      = PH_PAYLOAD;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			held_valid_q <= 1'b0;
			held_byte_q  <= 8'h00;
		end else if (advance) begin
			phase_q      <= phase_d;
			held_valid_q <= held_valid_d;
			held_byte_q  <= held_byte_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			payload_q <= held_byte_q;
			last_q    <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_q;
	assign frame_last   = last_q;

	// A byte is held only inside the payload part of a frame.
	`ASSERT_IMPLY(a_held_in_payload, clk, arst_n, held_valid_q,
		(phase_q == PH_PAYLOAD) || (phase_q == PH_ESCAPED))
	// A final byte always sends the receiver back to hunting for a flag.
	`ASSERT_NEXT(a_last_to_idle, clk, arst_n, advance && emit && emit_last,
		(phase_q == PH_IDLE) && !held_valid_q)
	// The state machine never moves while the result register is blocked.
	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_valid_q && out_stall,
		$stable(phase_q) && $stable(held_byte_q))
endmodule
`default_nettype wire

FILE: sim/hdlc_style_frame_receiver_top_test.sv
// Self-checking testbench for the HDLC-style frame receiver against a byte-level predictor.
`timescale 1ns / 100ps
module hdlc_style_frame_receiver_top_test;
	import hdlcfr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} payload_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	cfg_reg_t   cfg_index = REG_ADDRESS;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       frame_last;

	// Predictor state: register copies and the receiver's own state.
	logic [7:0] cfg_address = RESET_ADDRESS;
	logic [7:0] cfg_control = RESET_CONTROL;
	phase_t     rx_phase = PH_IDLE;
	logic [7:0] held_data = 8'h00;
	logic       held_full = 1'b0;
	payload_t   awaited_bytes[$];
	payload_t   oldest;

	int send_gap_pct = 0;
	int out_stall_pct = 0;
	int bytes_sent = 0;
	int bytes_checked = 0;
	int frames_closed = 0;
	int failures = 0;
	int cycle_count = 0;

	hdlc_style_frame_receiver_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.frame_last(frame_last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hdlc_style_frame_receiver_top: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// A held byte leaves when the next payload byte replaces it or a closing flag ends the frame.
	function void hold_payload(input logic [7:0] b);
		if (held_full)
			awaited_bytes.push_back('{held_data, 1'b0});
		held_data = b;
		held_full = 1'b1;
		rx_phase = PH_PAYLOAD;
	endfunction

	function void deframe_byte(input logic [7:0] c);
		case (rx_phase)
			PH_IDLE: begin
				if (c == FLAG_BYTE)
					rx_phase = PH_GOT_FLAG;
			end
			PH_GOT_FLAG: begin
				if (c == cfg_address)
					rx_phase = PH_GOT_ADDR;
				else if (c != FLAG_BYTE)
					rx_phase = PH_IDLE;
			end
			PH_GOT_ADDR: rx_phase = (c == cfg_control) ? PH_GOT_CTRL : PH_IDLE;
			PH_GOT_CTRL:
				rx_phase = (c == (cfg_address ^ cfg_control)) ? PH_HEADER_OK : PH_IDLE;
			PH_HEADER_OK: begin
				if (c == FLAG_BYTE)
					rx_phase = PH_SWALLOW;
				else if (c == ESC_BYTE)
					rx_phase = PH_ESCAPED;
				else
					hold_payload(c);
			end
			PH_SWALLOW: rx_phase = PH_IDLE;
			PH_PAYLOAD: begin
				if (c == FLAG_BYTE) begin
					if (held_full)
						awaited_bytes.push_back('{held_data, 1'b1});
					held_full = 1'b0;
					rx_phase = PH_IDLE;
				end else if (c == ESC_BYTE) begin
					rx_phase = PH_ESCAPED;
				end else begin
					hold_payload(c);
				end
			end
			default: hold_payload(c ^ ESC_XOR);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_bytes.size() == 0) begin
				$error("unexpected payload byte %02h (frame_last %b)", payload_byte, frame_last);
				failures++;
			end else begin
				oldest = awaited_bytes.pop_front();
				bytes_checked++;
				if (oldest.last)
					frames_closed++;
				if (payload_byte !== oldest.data) begin
					$error("payload_byte expected %02h actual %02h", oldest.data, payload_byte);
					failures++;
				end
				if (frame_last !== oldest.last) begin
					$error("frame_last expected %b actual %b", oldest.last, frame_last);
					failures++;
				end
			end
		end
	end

	// Called at a falling edge; returns at a falling edge.
	task send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_byte(b);
		bytes_sent++;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom_range(255));
			@(negedge clk);
		end
	endtask

	task settle();
		in_valid <= 1'b0;
		while (awaited_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_reg(input cfg_reg_t which, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (which)
			REG_ADDRESS: cfg_address = value;
			default: cfg_control = value;
		endcase
		@(negedge clk);
	endtask

	task send_payload(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: b = FLAG_BYTE;
				1: b = ESC_BYTE;
				default: b = 8'($urandom_range(255));
			endcase
			// Flags and escapes must be stuffed; other bytes are escaped now and then too.
			if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(15) == 0) begin
				send_byte(ESC_BYTE);
				send_byte(b ^ ESC_XOR);
			end else begin
				send_byte(b);
			end
		end
	endtask

	// A zero length gives a header-only frame, whose closing flag is followed by a swallowed byte.
	task send_frame(input logic [7:0] addr, input logic [7:0] ctrl, input logic [7:0] check,
			input int len, input bit close);
		send_byte(FLAG_BYTE);
		if ($urandom_range(7) == 0)
			send_byte(FLAG_BYTE);
		send_byte(addr);
		send_byte(ctrl);
		send_byte(check);
		send_payload(len);
		if (close) begin
			send_byte(FLAG_BYTE);
			if (len == 0)
				send_byte(8'($urandom_range(255)));
		end
	endtask

	task test_directed();
		logic [7:0] seq [24] = '{
			FLAG_BYTE, FLAG_BYTE, 8'h03, 8'h03, 8'h00, 8'h41, ESC_BYTE, 8'h5E, FLAG_BYTE,
			FLAG_BYTE, 8'h03, 8'h03, 8'h00, FLAG_BYTE, 8'h55,
			FLAG_BYTE, 8'h03, 8'h03, 8'h00, ESC_BYTE, 8'h5D, 8'h00, 8'hFF, FLAG_BYTE};
		send_gap_pct = 0;
		out_stall_pct = 0;
		foreach (seq[i])
			send_byte(seq[i]);
		settle();
	endtask

	task test_register_extremes();
		logic [7:0] pairs [6][2] = '{
			'{8'h00, 8'hFF}, '{8'hFF, 8'h00}, '{FLAG_BYTE, ESC_BYTE},
			'{ESC_BYTE, FLAG_BYTE}, '{8'hFF, 8'hFF}, '{8'h00, 8'h00}};
		send_gap_pct = 20;
		out_stall_pct = 20;
		foreach (pairs[i]) begin
			settle();
			write_reg(REG_ADDRESS, pairs[i][0]);
			write_reg(REG_CONTROL, pairs[i][1]);
			repeat (3)
				send_frame(cfg_address, cfg_control, cfg_address ^ cfg_control,
					$urandom_range(6), 1'b1);
		end
		settle();
	endtask

	// The control register changes after the address byte has already matched.
	task test_midframe_write();
		send_gap_pct = 0;
		out_stall_pct = 0;
		write_reg(REG_ADDRESS, 8'h5A);
		send_byte(FLAG_BYTE);
		send_byte(cfg_address);
		settle();
		write_reg(REG_CONTROL, 8'hC3);
		send_byte(cfg_control);
		send_byte(cfg_address ^ cfg_control);
		send_payload(4);
		send_byte(FLAG_BYTE);
		settle();
	endtask

	task random_traffic(input int n_bytes);
		int start;
		int kind;
		logic [7:0] flip;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			kind = $urandom_range(99);
			flip = 8'($urandom_range(1, 255));
			if (kind < 75) begin
				send_frame(cfg_address, cfg_control, cfg_address ^ cfg_control,
					($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8), 1'b1);
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 5))
					send_byte(($urandom_range(3) == 0) ? FLAG_BYTE : 8'($urandom_range(255)));
			end else if (kind < 85) begin
				send_frame(cfg_address ^ flip, cfg_control, cfg_address ^ cfg_control,
					$urandom_range(4), 1'b1);
			end else if (kind < 90) begin
				send_frame(cfg_address, cfg_control ^ flip, cfg_address ^ cfg_control,
					$urandom_range(4), 1'b1);
			end else if (kind < 95) begin
				send_frame(cfg_address, cfg_control, cfg_address ^ cfg_control ^ flip,
					$urandom_range(4), 1'b1);
			end else begin
				// Unterminated frame: the next opening flag closes it instead.
				send_frame(cfg_address, cfg_control, cfg_address ^ cfg_control,
					$urandom_range(6), 1'b0);
			end
			if ($urandom_range(39) == 0)
				settle();
		end
	endtask

	task test_random_phases();
		int gap_pcts [4] = '{0, 47, 0, 8};
		int stall_pcts [4] = '{0, 0, 47, 8};
		for (int p = 0; p < 4; p++) begin
			settle();
			send_gap_pct = gap_pcts[p];
			out_stall_pct = stall_pcts[p];
			write_reg(REG_ADDRESS,
				($urandom_range(3) == 0) ? RESET_ADDRESS : 8'($urandom_range(255)));
			write_reg(REG_CONTROL,
				($urandom_range(3) == 0) ? RESET_CONTROL : 8'($urandom_range(255)));
			random_traffic(240);
		end
		settle();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_extremes();
		test_midframe_write();
		test_random_phases();
		out_stall_pct = 0;
		settle();
		$display("Sent %0d raw bytes under directed, extreme-register and four idling phases.",
			bytes_sent);
		$display("Checked %0d payload bytes, %0d of them closing a frame.",
			bytes_checked, frames_closed);
		if (failures == 0)
			$display("hdlc_style_frame_receiver_top: match");
		else
			$display("hdlc_style_frame_receiver_top: mismatch");
		$finish;
	end
endmodule
